FILE: hw/rtl/nearest_waypoint_lookahead_window_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef NEAREST_WAYPOINT_LOOKAHEAD_WINDOW_UNIT_ASSERT_SVH
`define NEAREST_WAYPOINT_LOOKAHEAD_WINDOW_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define NWL_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("nwl assertion failed");

// Next-cycle implication, off during reset.
`define NWL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("nwl assertion failed");

// Next-cycle implication, active through reset.
`define NWL_ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("nwl assertion failed");

`endif

FILE: hw/rtl/nwl_pkg.sv
`default_nettype none
package nwl_pkg;

   localparam int COORD_W   = 32;
   localparam int SEG_W     = 32;
   localparam int ABS_W     = 33;
   localparam int SQ_W      = 66;
   localparam int DIST_W    = 66;
   localparam int IDX_OUT_W = 10;
   localparam int CNT_OUT_W = 11;
   localparam int MIN_POINTS = 2;

   localparam logic [31:0] LOOKAHEAD_RESET = 32'd655360;

   // action codes
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      point_type          pt;
      logic [SEG_W-1:0]   seg;
   } entry_type;

endpackage
`default_nettype wire

FILE: hw/rtl/nwl_dist.sv
`default_nettype none
// Squared Euclidean distance, three-stage pipeline, one pair per cycle.
module nwl_dist import nwl_pkg::*; #(
   parameter int TAG_W = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_vld,
   input  wire logic [TAG_W-1:0]  in_tag,
   input  wire point_type         pt_a,
   input  wire point_type         pt_b,
   output logic                   out_vld,
   output logic [TAG_W-1:0]       out_tag,
   output logic [DIST_W-1:0]      out_dist
);

   logic [2:0]             vld_ff;
   logic [TAG_W-1:0]       tag1_ff, tag2_ff, tag3_ff;
   logic [ABS_W-1:0]       ax_ff, ay_ff, az_ff;
   logic [SQ_W-1:0]        sx_ff, sy_ff, sz_ff;
   logic [DIST_W-1:0]      sum_ff;
   logic signed [ABS_W-1:0] dx, dy, dz;
   logic [ABS_W-1:0]       ax_in, ay_in, az_in;

   // stage 1: absolute differences
   always_comb begin
      dx = ABS_W'(pt_a.x) - ABS_W'(pt_b.x);
      dy = ABS_W'(pt_a.y) - ABS_W'(pt_b.y);
      dz = ABS_W'(pt_a.z) - ABS_W'(pt_b.z);
      ax_in = dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
      ay_in = dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
      az_in = dz[ABS_W-1] ? ABS_W'(-dz) : ABS_W'(dz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_vld};
      end
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      az_ff   <= az_in;
      tag1_ff <= in_tag;
      // stage 2: squares
      sx_ff   <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
      sy_ff   <= SQ_W'(ay_ff) * SQ_W'(ay_ff);
      sz_ff   <= SQ_W'(az_ff) * SQ_W'(az_ff);
      tag2_ff <= tag1_ff;
      // stage 3: sum
      sum_ff  <= sx_ff + sy_ff + sz_ff;
      tag3_ff <= tag2_ff;
   end

   assign out_vld  = vld_ff[2];
   assign out_tag  = tag3_ff;
   assign out_dist = sum_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/nwl_sqrt.sv
`default_nettype none
// Bit-serial integer square root, one result bit per cycle, saturating.
module nwl_sqrt import nwl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIST_W-1:0] value,
   output logic                   done,
   output logic [SEG_W-1:0]       root
);

   logic                busy_ff;
   logic                done_ff;
   logic                sat_ff;
   logic [5:0]          cnt_ff;
   logic [63:0]         rad_ff;
   logic [33:0]         rem_ff;
   logic [SEG_W-1:0]    root_ff;
   logic [35:0]         rem_cur;
   logic [35:0]         trial;
   logic                fits;

   // one radicand digit pair per step
   always_comb begin
      rem_cur = {rem_ff, rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      fits    = (rem_cur >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 6'd1);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == 6'd1)) begin
            busy_ff <= 1'b0;
         end
      end
      if (start) begin
         rad_ff  <= value[63:0];
         sat_ff  <= (value[DIST_W-1:64] != '0);
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= 6'd32;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[61:0], 2'b00};
         rem_ff  <= fits ? 34'(rem_cur - trial) : rem_cur[33:0];
         root_ff <= {root_ff[SEG_W-2:0], fits};
         cnt_ff  <= cnt_ff - 6'd1;
      end
   end

   assign done = done_ff;
   assign root = sat_ff ? '1 : root_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/nearest_waypoint_lookahead_window_unit.sv
// Append: the first point is written directly; a later one goes through a table read, the
// 3-stage distance pipe, a 32-step square root and a write. Clear resets the point count.
// Query: scans the N stored points through the single table read port, then walks segment
// lengths ahead of the nearest point and loads the result; fewer than two points skip both.
// One item in flight; the next is taken while a finished result waits in the output register.
// Synchronous active-high reset empties the table and sets lookahead to 10.0 m.
`default_nettype none
module nearest_waypoint_lookahead_window_unit import nwl_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_action,
   input  wire logic signed [31:0]    req_pos_x,
   input  wire logic signed [31:0]    req_pos_y,
   input  wire logic signed [31:0]    req_pos_z,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_window_valid,
   output logic [9:0]                 rsp_start_index,
   output logic [9:0]                 rsp_end_index,
   output logic [10:0]                rsp_window_count,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [31:0]           csr_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] MIN_CNT   = CNT_W'(MIN_POINTS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_APP_DIST, ST_APP_ROOT, ST_SCAN, ST_WALK, ST_DONE
   } state_type;

   // waypoint table
   entry_type table_mem [TABLE_DEPTH];
   entry_type mem_rd_ff;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic [IDX_W-1:0]   best_ff, best_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]   end_ff, end_in;
   logic [SEG_W-1:0]   sum_ff, sum_in;
   logic               win_ff, win_in;
   point_type          pose_ff, pose_in;
   logic [31:0]        lookahead_ff, lookahead_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_win_ff, rsp_win_in;
   logic [9:0]         rsp_start_ff, rsp_start_in;
   logic [9:0]         rsp_end_ff, rsp_end_in;
   logic [10:0]        rsp_count_ff, rsp_count_in;
   logic               rd_vld_ff, rd_dist_ff;
   logic [IDX_W-1:0]   rd_idx_ff;

   logic               rd_en, rd_dist, wr_en;
   logic [IDX_W-1:0]   rd_addr, wr_addr, last_idx;
   entry_type          wr_data;
   logic [CNT_W-1:0]   cnt_m1;

   logic               dist_vld;
   logic [IDX_W-1:0]   dist_tag;
   logic [DIST_W-1:0]  dist_val;
   logic               sqrt_start, sqrt_done;
   logic [SEG_W-1:0]   sqrt_root;

   logic               take;
   logic [IDX_W-1:0]   nb;
   logic [SEG_W:0]     seg_sum;
   logic [SEG_W-1:0]   sum_sat;
   logic [31:0]        best_w, end_w, span_w;

   assign cnt_m1   = count_ff - CNT_W'(1);
   assign last_idx = cnt_m1[IDX_W-1:0];

   nwl_dist #(.TAG_W(IDX_W)) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (rd_vld_ff && rd_dist_ff),
      .in_tag   (rd_idx_ff),
      .pt_a     (pose_ff),
      .pt_b     (mem_rd_ff.pt),
      .out_vld  (dist_vld),
      .out_tag  (dist_tag),
      .out_dist (dist_val)
   );

   nwl_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (dist_val),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // control and next-state logic
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      best_in      = best_ff;
      best_dist_in = best_dist_ff;
      end_in       = end_ff;
      sum_in       = sum_ff;
      win_in       = win_ff;
      pose_in      = pose_ff;
      lookahead_in = lookahead_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_win_in   = rsp_win_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_count_in = rsp_count_ff;
      rd_en        = 1'b0;
      rd_dist      = 1'b0;
      rd_addr      = issue_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data.pt   = pose_ff;
      wr_data.seg  = sqrt_root;
      sqrt_start   = 1'b0;
      take         = (dist_tag == '0) || (dist_val < best_dist_ff);
      nb           = take ? dist_tag : best_ff;
      seg_sum      = {1'b0, sum_ff} + {1'b0, mem_rd_ff.seg};
      sum_sat      = seg_sum[SEG_W] ? '1 : seg_sum[SEG_W-1:0];
      best_w       = 32'(best_ff);
      end_w        = 32'(end_ff);
      span_w       = end_w - best_w + 32'd1;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid) begin
         lookahead_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pose_in = '{x: req_pos_x, y: req_pos_y, z: req_pos_z};
               unique case (req_action)
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ACT_APPEND: begin
                     if (count_ff != DEPTH_CNT) begin
                        if (count_ff == '0) begin
                           wr_en       = 1'b1;
                           wr_data.pt  = pose_in;
                           wr_data.seg = '0;
                           count_in    = count_ff + CNT_W'(1);
                        end else begin
                           rd_en    = 1'b1;
                           rd_dist  = 1'b1;
                           rd_addr  = last_idx;
                           state_in = ST_APP_DIST;
                        end
                     end
                  end
                  ACT_QUERY: begin
                     if (count_ff < MIN_CNT) begin
                        win_in   = 1'b0;
                        best_in  = '0;
                        end_in   = '0;
                        state_in = ST_DONE;
                     end else begin
                        win_in   = 1'b1;
                        issue_in = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_APP_DIST: begin
            if (dist_vld) begin
               sqrt_start = 1'b1;
               state_in   = ST_APP_ROOT;
            end
         end
         ST_APP_ROOT: begin
            if (sqrt_done) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // stream every stored point through the distance pipe
            if (issue_ff != count_ff) begin
               rd_en    = 1'b1;
               rd_dist  = 1'b1;
               issue_in = issue_ff + CNT_W'(1);
            end
            if (dist_vld) begin
               if (take) begin
                  best_in      = dist_tag;
                  best_dist_in = dist_val;
               end
               if (dist_tag == last_idx) begin
                  end_in   = nb;
                  sum_in   = '0;
                  issue_in = CNT_W'(nb) + CNT_W'(1);
                  state_in = (nb == last_idx) ? ST_DONE : ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // accumulate segment lengths ahead of the nearest point
            if (issue_ff != count_ff) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + CNT_W'(1);
            end
            if (rd_vld_ff && !rd_dist_ff) begin
               sum_in = sum_sat;
               end_in = rd_idx_ff;
               if ((sum_sat > lookahead_ff) || (rd_idx_ff == last_idx)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_win_in   = win_ff;
               rsp_start_in = best_w[9:0];
               rsp_end_in   = end_w[9:0];
               rsp_count_in = win_ff ? span_w[10:0] : 11'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         lookahead_ff <= LOOKAHEAD_RESET;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lookahead_ff <= lookahead_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_en;
      end
      issue_ff     <= issue_in;
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      end_ff       <= end_in;
      sum_ff       <= sum_in;
      win_ff       <= win_in;
      pose_ff      <= pose_in;
      rsp_win_ff   <= rsp_win_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_count_ff <= rsp_count_in;
      rd_dist_ff   <= rd_dist;
      rd_idx_ff    <= rd_addr;
   end

   // table memory, one read and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff <= table_mem[rd_addr];
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_valid = rsp_win_ff;
   assign rsp_start_index  = rsp_start_ff;
   assign rsp_end_index    = rsp_end_ff;
   assign rsp_window_count = rsp_count_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/nwl_checker.sv
`default_nettype none
`include "nearest_waypoint_lookahead_window_unit_assert.svh"
// Port-level checks for the waypoint window unit.
module nwl_checker import nwl_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_action,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_window_valid,
   input wire logic [9:0]  rsp_start_index,
   input wire logic [9:0]  rsp_end_index,
   input wire logic [10:0] rsp_window_count
);

   logic zero_fields;
   logic span_ok;
   logic query_beat;

   assign zero_fields = (rsp_start_index == 10'd0) && (rsp_end_index == 10'd0) &&
                        (rsp_window_count == 11'd0);
   assign span_ok     = rsp_window_count[9:0] == 10'(rsp_end_index - rsp_start_index + 10'd1);
   assign query_beat  = req_valid && req_ready && (req_action == ACT_QUERY);

   // a stalled result beat stays up
   `NWL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // too few points gives an all-zero result
   `NWL_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && !rsp_window_valid, zero_fields)

   // window count matches its indices
   `NWL_ASSERT_IMPLY(a_count_span, clock, reset, rsp_valid && rsp_window_valid, span_ok)

   // a query keeps the input busy for at least the next cycle
   `NWL_ASSERT_NEXT(a_query_busy, clock, reset, query_beat, !req_ready)

   // reset leaves no result pending
   `NWL_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind nearest_waypoint_lookahead_window_unit nwl_checker u_nwl_checker (.*);
`default_nettype wire
